// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, constants and helpers for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int DEFAULT_SLOTS = 1024;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int SLOT_W        = 10;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_DONE    = 1'b0,
        STATUS_NO_FREE = 1'b1
    } status_t;

    typedef struct packed {
        cmd_t              command;
        logic [SLOT_W-1:0] slot_index;
    } bsa_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        status_t           status;
    } bsa_rsp_t;

    // Word-full summary update from the modify stage
    typedef struct packed {
        logic we;
        logic full;
    } bsa_sum_upd_t;

    // Lowest zero bit of a word that is known not to be full
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
        logic [BIT_W-1:0]  pos;
        logic [WORD_W-1:0] m;
        pos = '0;
        m   = word;
        if (m[15:0] == 16'hffff)
        begin
            pos = pos + 5'd16;
            m   = m >> 16;
        end
        if (m[7:0] == 8'hff)
        begin
            pos = pos + 5'd8;
            m   = m >> 8;
        end
        if (m[3:0] == 4'hf)
        begin
            pos = pos + 5'd4;
            m   = m >> 4;
        end
        if (m[1:0] == 2'b11)
        begin
            pos = pos + 5'd2;
            m   = m >> 2;
        end
        if (m[0])
        begin
            pos = pos + 5'd1;
        end
        return pos;
    endfunction

endpackage

// ----- hdl/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Used-slot bitmap with lowest-free allocation and release by slot number.
// ----------------------------------------------------------------------------
// The result strobe (done) is registered from the modify state that follows acceptance.
// No new transaction is taken while one is in its modify state; each does the read-modify-write
//   of one bitmap word through the single map memory (read, then write back).
// busy is high for the cycle after acceptance only; results cannot be stalled.
// Reset: async, clears control state; the map reads as all free at once,
//   words beyond the high-water count read as zero, so no clearing pass.
module bitmap_slot_allocator #(
    parameter int SLOTS = bsa_pkg::DEFAULT_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bsa_pkg::bsa_req_t request,
    output logic              busy,
    output logic              done,
    output bsa_pkg::bsa_rsp_t result
);

    localparam int MAP_WORDS  = (SLOTS + 31) / 32;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LAST_VALID = SLOTS - 32 * (MAP_WORDS - 1);
    localparam logic [bsa_pkg::WORD_W-1:0] TAIL_MASK =
        (LAST_VALID == 32) ? '0 : (32'hffff_ffff << LAST_VALID);

    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

    state_t                      state_reg, state_next;
    bsa_pkg::cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [bsa_pkg::BIT_W-1:0]   bit_reg, bit_next;
    logic                        skip_reg, skip_next;
    logic [AW:0]                 hwm_reg, hwm_next;
    logic                        done_reg, done_next;
    bsa_pkg::bsa_rsp_t           result_reg, result_next;

    logic                        accept;
    logic                        free_found;
    logic [AW-1:0]               free_idx;
    logic [AW+4:0]               rel_word_wide;
    logic [bsa_pkg::WORD_W-1:0]  rdata;
    logic [bsa_pkg::WORD_W-1:0]  word_cur;
    logic [bsa_pkg::WORD_W-1:0]  view;
    logic [bsa_pkg::BIT_W-1:0]   alloc_bit;
    logic [bsa_pkg::WORD_W-1:0]  alloc_onehot;
    logic [AW+14:0]              slot_wide;
    logic                        mem_we;
    logic [bsa_pkg::WORD_W-1:0]  mem_wdata;
    bsa_pkg::bsa_sum_upd_t       sum_upd;

    assign busy   = (state_reg == ST_MODIFY);
    assign accept = start && !busy;

    assign rel_word_wide = {{AW{1'b0}}, request.slot_index[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W]};

    bsa_summary #(
        .WORDS (MAP_WORDS),
        .AW    (AW)
    ) u_summary (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (sum_upd),
        .upd_addr  (addr_reg),
        .found     (free_found),
        .first_idx (free_idx)
    );

    bsa_map_ram #(
        .WORDS (MAP_WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (addr_next),
        .rdata (rdata)
    );

    // Modify stage: words past the high-water count were never written
    always_comb
    begin
        word_cur     = ({1'b0, addr_reg} < hwm_reg) ? rdata : '0;
        view         = word_cur | ((addr_reg == AW'(MAP_WORDS - 1)) ? TAIL_MASK : '0);
        alloc_bit    = bsa_pkg::lowest_zero(view);
        alloc_onehot = bsa_pkg::WORD_W'(1) << alloc_bit;
        slot_wide    = {10'b0, addr_reg, alloc_bit};
        mem_we       = 1'b0;
        mem_wdata    = word_cur;
        sum_upd.we   = 1'b0;
        sum_upd.full = 1'b0;
        if (state_reg == ST_MODIFY)
        begin
            if (cmd_reg == bsa_pkg::CMD_ALLOC)
            begin
                mem_we       = !skip_reg;
                mem_wdata    = word_cur | alloc_onehot;
                sum_upd.full = &(view | alloc_onehot);
            end
            else
            begin
                mem_we       = !skip_reg && ({1'b0, addr_reg} < hwm_reg);
                mem_wdata    = word_cur & ~(bsa_pkg::WORD_W'(1) << bit_reg);
                sum_upd.full = 1'b0;
            end
            sum_upd.we = mem_we;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        bit_next    = bit_reg;
        skip_next   = skip_reg;
        hwm_next    = hwm_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = request.command;
                    bit_next = request.slot_index[bsa_pkg::BIT_W-1:0];
                    if (request.command == bsa_pkg::CMD_RELEASE)
                    begin
                        addr_next = rel_word_wide[AW-1:0];
                        skip_next = !(32'(request.slot_index) < 32'(SLOTS));
                    end
                    else
                    begin
                        addr_next = free_idx;
                        skip_next = !free_found;
                    end
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                done_next = 1'b1;
                if (cmd_reg == bsa_pkg::CMD_ALLOC && !skip_reg)
                begin
                    result_next.granted_slot = slot_wide[bsa_pkg::SLOT_W-1:0];
                    result_next.status       = bsa_pkg::STATUS_DONE;
                    if ({1'b0, addr_reg} == hwm_reg)
                    begin
                        hwm_next = hwm_reg + 1'b1;
                    end
                end
                else
                begin
                    result_next.granted_slot = '0;
                    result_next.status       = (cmd_reg == bsa_pkg::CMD_ALLOC)
                                               ? bsa_pkg::STATUS_NO_FREE
                                               : bsa_pkg::STATUS_DONE;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= bsa_pkg::CMD_ALLOC;
            addr_reg   <= '0;
            bit_reg    <= '0;
            skip_reg   <= 1'b0;
            hwm_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            addr_reg   <= addr_next;
            bit_reg    <= bit_next;
            skip_reg   <= skip_next;
            hwm_reg    <= hwm_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A transaction occupies exactly one modify cycle
    a_modify_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |=> (state_reg == ST_IDLE))
        else $error("modify stage held for more than one cycle");

    // Every accepted transaction yields a result strobe after its modify state
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted transaction produced no result");

    // No result without a preceding modify cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_MODIFY))
        else $error("result strobe without a transaction");

    // A failed allocate leaves every word still marked full
    a_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == bsa_pkg::STATUS_NO_FREE) |-> !free_found)
        else $error("allocate reported no free slot while one is free");

    // High-water count never runs past the map
    a_hwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(hwm_reg) <= 32'(MAP_WORDS)))
        else $error("high-water count beyond map depth");

endmodule

// ----- hdl/bsa_map_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_map_ram
// Used-slot bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsa_map_ram #(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bsa_pkg::WORD_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bsa_pkg::WORD_W-1:0]  rdata
);

    logic [bsa_pkg::WORD_W-1:0] mem [WORDS];
    logic [bsa_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bsa_summary.sv -----
// ----------------------------------------------------------------------------
// bsa_summary
// One full flag per bitmap word and a search for the lowest word not full.
// ----------------------------------------------------------------------------
module bsa_summary #(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsa_pkg::bsa_sum_upd_t upd,
    input  logic [AW-1:0]         upd_addr,
    output logic                  found,
    output logic [AW-1:0]         first_idx
);

    logic [WORDS-1:0] full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (upd.we)
        begin
            full_reg[upd_addr] <= upd.full;
        end
    end

    // scan from the top so the lowest clear flag wins
    always_comb
    begin
        found     = 1'b0;
        first_idx = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                found     = 1'b1;
                first_idx = AW'(i);
            end
        end
    end

endmodule

// ----- verif/bitmap_slot_allocator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_test
// Self-checking bench for the slot allocator: directed allocate and release
// transactions, a fill to a full map and random churn, with every result
// compared against a bitmap kept beside the block.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_test;

    import bsa_pkg::*;

    localparam int SLOT_COUNT    = DEFAULT_SLOTS;
    localparam int MAP_WORDS     = SLOT_COUNT / WORD_W;
    localparam int REQ_W         = $bits(bsa_req_t);
    localparam int MAX_GAP       = 10;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 200000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    bsa_req_t request;
    bsa_rsp_t result;

    // Slot bitmap as the allocator should hold it, updated at each acceptance
    logic [WORD_W-1:0] slot_words [MAP_WORDS];
    int                slots_taken;
    bsa_rsp_t          pending_grants [$];
    int                mismatch_count;
    int                cycle_count;
    bit                steady_sender;

    bitmap_slot_allocator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit slot_taken(input logic [SLOT_W-1:0] idx);
        return slot_words[idx[SLOT_W-1:BIT_W]][idx[BIT_W-1:0]];
    endfunction

    // Apply one transaction to the bitmap and return the response it should give
    function automatic bsa_rsp_t apply_transaction(input bsa_req_t req);
        bsa_rsp_t rsp;
        bit       found;
        int       w;
        int       b;
        rsp.granted_slot = '0;
        rsp.status       = STATUS_DONE;
        found            = 1'b0;
        if (req.command == CMD_RELEASE)
        begin
            if (slot_taken(req.slot_index))
            begin
                slot_words[req.slot_index[SLOT_W-1:BIT_W]][req.slot_index[BIT_W-1:0]] = 1'b0;
                slots_taken--;
            end
        end
        else
        begin
            for (w = 0; w < MAP_WORDS && !found; w++)
            begin
                if (slot_words[w] != '1)
                begin
                    for (b = 0; b < WORD_W && !found; b++)
                    begin
                        if (!slot_words[w][b])
                        begin
                            slot_words[w][b] = 1'b1;
                            slots_taken++;
                            rsp.granted_slot = SLOT_W'(w * WORD_W + b);
                            found = 1'b1;
                        end
                    end
                end
            end
            if (!found)
                rsp.status = STATUS_NO_FREE;
        end
        return rsp;
    endfunction

    // Mostly a slot that is taken, otherwise any slot at all
    function automatic logic [SLOT_W-1:0] pick_release_slot();
        logic [SLOT_W-1:0] idx;
        int                n;
        idx = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        if ($urandom_range(0, 4) != 0 && slots_taken != 0)
        begin
            for (n = 0; n < SLOT_COUNT && !slot_taken(idx); n++)
                idx = idx + 1'b1;
        end
        return idx;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_transaction(input cmd_t cmd, input logic [SLOT_W-1:0] idx);
        bsa_req_t         req;
        logic [REQ_W-1:0] noise;
        int               gap;
        req.command    = cmd;
        req.slot_index = idx;
        if ($urandom_range(0, 39) == 0)
            steady_sender = !steady_sender;
        gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                noise = REQ_W'($urandom);
                request <= noise;
                @(posedge clk);
            end
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        pending_grants.push_back(apply_transaction(req));
    endtask

    task automatic send_allocate();
        send_transaction(CMD_ALLOC, SLOT_W'($urandom));
    endtask

    // Hold the sender off until every outstanding response has arrived
    task automatic wait_for_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_first_allocations();
        send_transaction(CMD_ALLOC, '1);
        send_transaction(CMD_ALLOC, '0);
        send_allocate();
    endtask

    task automatic test_release_paths();
        send_transaction(CMD_RELEASE, SLOT_W'(1));
        send_allocate();
        // releases of slots that are already free, and of slot 0 twice (taken, then free)
        send_transaction(CMD_RELEASE, '1);
        send_transaction(CMD_RELEASE, 10'h2aa);
        send_transaction(CMD_RELEASE, 10'h155);
        send_transaction(CMD_RELEASE, '0);
        send_transaction(CMD_RELEASE, '0);
        send_allocate();
        send_allocate();
        wait_for_quiet();
    endtask

    task automatic test_fill_to_full();
        while (slots_taken < SLOT_COUNT)
        begin
            if ($urandom_range(0, 11) == 0)
                send_transaction(CMD_RELEASE, pick_release_slot());
            else
                send_allocate();
        end
    endtask

    task automatic test_full_map();
        repeat (3)
            send_allocate();
        send_transaction(CMD_RELEASE, SLOT_W'(SLOT_COUNT - 1));
        send_allocate();
        send_transaction(CMD_RELEASE, '0);
        send_allocate();
        send_transaction(CMD_RELEASE, SLOT_W'(32));
        send_transaction(CMD_RELEASE, SLOT_W'(31));
        send_transaction(CMD_RELEASE, SLOT_W'(512));
        repeat (4)
            send_allocate();
        wait_for_quiet();
    endtask

    task automatic test_random_churn();
        repeat (40)
        begin
            if ($urandom_range(0, 1) == 0)
                send_transaction(CMD_RELEASE, pick_release_slot());
            else
                send_allocate();
        end
    endtask

    // Compare each response with the oldest outstanding expectation
    always @(posedge clk)
    begin
        bsa_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response slot=%0d status=%0d",
                                          result.granted_slot, result.status));
            end
            else
            begin
                want = pending_grants.pop_front();
                if (result.granted_slot !== want.granted_slot)
                    report_mismatch($sformatf("granted_slot expected %0d got %0d",
                                              want.granted_slot, result.granted_slot));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status expected %0d got %0d",
                                              want.status, result.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        slots_taken    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        steady_sender  = 1'b0;
        foreach (slot_words[w])
            slot_words[w] = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_allocations();
        test_release_paths();
        test_fill_to_full();
        test_full_map();
        test_random_churn();

        wait_for_quiet();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bsa_pkg.sv
hdl/bsa_map_ram.sv
hdl/bsa_summary.sv
hdl/bitmap_slot_allocator.sv
verif/bitmap_slot_allocator_test.sv
